>>> design/dcm_pkg.sv
// dcm_pkg: shared types, codes and saturation helper for the dc motor torque block
`default_nettype none
package dcm_pkg;

    localparam int Q_W      = 32;  // q16.16 word
    localparam int PROD_W   = 64;  // full product of two q words
    localparam int SHIFT_W  = 48;  // product after dropping 16 fraction bits
    localparam int REG_W    = 31;  // widest configuration register
    localparam int EFF_W    = 17;  // efficiency register
    localparam int DT_W     = 16;  // tick length
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 3;
    localparam int RAD_W    = 48;  // square root radicand
    localparam int ROOT_W   = 24;  // square root result
    localparam int SQ_CNT_W = 5;

    typedef logic signed [Q_W-1:0]     t_q;
    typedef logic signed [SHIFT_W-1:0] t_wide;

    // opcodes
    localparam logic [OP_W-1:0] OP_DUTY  = 2'd0;
    localparam logic [OP_W-1:0] OP_SPEED = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_SUPPLY   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_KE       = 3'd1;
    localparam logic [ADDR_W-1:0] REG_GEAR     = 3'd2;
    localparam logic [ADDR_W-1:0] REG_RES      = 3'd3;
    localparam logic [ADDR_W-1:0] REG_INV_L    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_KT       = 3'd5;
    localparam logic [ADDR_W-1:0] REG_EFF      = 3'd6;
    localparam logic [ADDR_W-1:0] REG_FRICTION = 3'd7;

    localparam t_wide SAT_HI = 48'sh0000_7FFF_FFFF;
    localparam t_wide SAT_LO = 48'shFFFF_8000_0000;

    // clamp a wide signed value into the q16.16 range
    function automatic t_q sat32(input t_wide x);
        t_q r;
        if (x > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[Q_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/dcm_sqrt.sv
// dcm_sqrt: restoring integer square root, one result bit per cycle
`default_nettype none
module dcm_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [dcm_pkg::RAD_W-1:0]   i_radicand,
    output logic                             o_done,
    output logic [dcm_pkg::ROOT_W-1:0]       o_root
);

    localparam int REM_W = dcm_pkg::ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;
    localparam logic [dcm_pkg::SQ_CNT_W-1:0] LAST = dcm_pkg::SQ_CNT_W'(dcm_pkg::ROOT_W - 1);

    logic                            r_busy;
    logic [dcm_pkg::SQ_CNT_W-1:0]    r_cnt;
    logic [dcm_pkg::RAD_W-1:0]       r_x;
    logic [REM_W-1:0]                r_rem;
    logic [dcm_pkg::ROOT_W-1:0]      r_root;

    logic [TRY_W-1:0] rem_sh;
    logic [TRY_W-1:0] trial;
    logic             fits;

    assign rem_sh = {r_rem, r_x[dcm_pkg::RAD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[dcm_pkg::RAD_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[dcm_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(rem_sh);
                r_root <= {r_root[dcm_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // high in the cycle of the last iteration; root is final after that edge
    assign o_done = r_busy && (r_cnt == LAST);
    assign o_root = r_root;

endmodule
`default_nettype wire

>>> design/dcm_mul.sv
// dcm_mul: shared registered signed multiplier with q16.16 floor scaling
`default_nettype none
module dcm_mul (
    input  wire logic           i_clk,
    input  wire logic           i_load,
    input  wire dcm_pkg::t_q    i_a,
    input  wire dcm_pkg::t_q    i_b,
    output dcm_pkg::t_wide      o_q
);

    logic signed [dcm_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= i_a * i_b;
        end
    end

    // dropping the low bits of a two's complement product rounds toward minus infinity
    assign o_q = r_prod[dcm_pkg::PROD_W-1:16];

endmodule
`default_nettype wire

>>> design/dc_motor_current_torque_step.sv
// dc_motor_current_torque_step: brushed dc motor armature model, q16.16, one shared multiplier
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | in        | i_in_valid / o_in_stall   | i_opcode, i_value, i_step_time
//  out     | out       | o_out_valid / i_out_stall | o_torque
//  cfg     | in        | i_cfg_we                  | i_cfg_addr, i_cfg_data
//
// a duty beat busies the block for 24 square root iterations, one bit a cycle,
//   then one pass through the shared multiplier
// a tick beat busies it for eight multiplies on the shared multiplier, each with
//   a load phase and a result phase, plus three saturating add steps, and it stays
//   busy while the last torque beat is still held by i_out_stall
// speed beats and the unused opcode leave the sequencer idle and give no output beat
// synchronous active-low reset: motor state to zero, registers to their defaults
// the output register holds one torque beat, so a duty or speed beat is taken
//   while that beat waits
`default_nettype none
module dc_motor_current_torque_step (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input beats
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [dcm_pkg::OP_W-1:0]      i_opcode,
    input  wire logic signed [dcm_pkg::Q_W-1:0] i_value,
    input  wire logic [dcm_pkg::DT_W-1:0]      i_step_time,
    // output beats
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [dcm_pkg::Q_W-1:0]     o_torque,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [dcm_pkg::ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [dcm_pkg::REG_W-1:0]     i_cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQRT  = 4'd1;
    localparam logic [3:0] S_VMUL  = 4'd2;
    localparam logic [3:0] S_KETR  = 4'd3;
    localparam logic [3:0] S_BEMF  = 4'd4;
    localparam logic [3:0] S_RDROP = 4'd5;
    localparam logic [3:0] S_DIFF  = 4'd6;
    localparam logic [3:0] S_IDOT  = 4'd7;
    localparam logic [3:0] S_DELTA = 4'd8;
    localparam logic [3:0] S_CUR   = 4'd9;
    localparam logic [3:0] S_KM    = 4'd10;
    localparam logic [3:0] S_NET   = 4'd11;
    localparam logic [3:0] S_GEFF  = 4'd12;
    localparam logic [3:0] S_TAU   = 4'd13;

    // configuration registers
    logic [dcm_pkg::REG_W-1:0] r_supply, r_ke, r_gear, r_res, r_inv_l, r_kt, r_friction;
    logic [dcm_pkg::EFF_W-1:0] r_eff;

    // motor state
    dcm_pkg::t_q r_drive, r_speed, r_cur;

    // working registers
    dcm_pkg::t_q               r_ta, r_tb;
    logic [dcm_pkg::DT_W-1:0]  r_dt;
    logic                      r_neg;

    // sequencer
    logic [3:0] r_state, n_state;
    logic       r_ph, n_ph;

    // output register
    logic        r_out_valid;
    dcm_pkg::t_q r_torque;

    logic in_take;
    logic is_mul;
    logic mul_load;
    logic out_free;
    logic sq_start, sq_done;
    logic [dcm_pkg::ROOT_W-1:0] sq_root;
    logic [dcm_pkg::Q_W-1:0]    mag;
    dcm_pkg::t_q   mul_a, mul_b;
    dcm_pkg::t_wide mul_q;
    dcm_pkg::t_wide sum;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // configuration write port, values masked to register widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply   <= 31'd786432;
            r_ke       <= 31'd65536;
            r_gear     <= 31'd65536;
            r_res      <= 31'd65536;
            r_inv_l    <= 31'd65536;
            r_kt       <= 31'd65536;
            r_eff      <= 17'd65536;
            r_friction <= 31'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dcm_pkg::REG_SUPPLY:   r_supply   <= i_cfg_data;
                dcm_pkg::REG_KE:       r_ke       <= i_cfg_data;
                dcm_pkg::REG_GEAR:     r_gear     <= i_cfg_data;
                dcm_pkg::REG_RES:      r_res      <= i_cfg_data;
                dcm_pkg::REG_INV_L:    r_inv_l    <= i_cfg_data;
                dcm_pkg::REG_KT:       r_kt       <= i_cfg_data;
                dcm_pkg::REG_EFF:      r_eff      <= i_cfg_data[dcm_pkg::EFF_W-1:0];
                dcm_pkg::REG_FRICTION: r_friction <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // square root of |duty| scaled by 2^16
    assign mag      = i_value[dcm_pkg::Q_W-1] ? (-i_value) : i_value;
    assign sq_start = in_take && (i_opcode == dcm_pkg::OP_DUTY);

    dcm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand ({mag, 16'd0}),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // multiply steps: first phase loads the product, second phase takes the result
    always_comb begin
        unique case (r_state) inside
            S_VMUL, S_KETR, S_BEMF, S_RDROP, S_IDOT, S_DELTA, S_KM, S_GEFF, S_TAU:
                is_mul = 1'b1;
            default:
                is_mul = 1'b0;
        endcase
    end
    assign mul_load = is_mul && !r_ph;

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = r_ta;
        mul_b = r_ta;
        unique case (r_state)
            S_VMUL: begin
                mul_a = {8'd0, sq_root};
                mul_b = {1'b0, r_supply};
            end
            S_KETR: begin
                mul_a = {1'b0, r_ke};
                mul_b = {1'b0, r_gear};
            end
            S_BEMF: begin
                mul_a = r_ta;
                mul_b = r_speed;
            end
            S_RDROP: begin
                mul_a = {1'b0, r_res};
                mul_b = r_cur;
            end
            S_IDOT: begin
                mul_a = r_ta;
                mul_b = {1'b0, r_inv_l};
            end
            S_DELTA: begin
                mul_a = r_ta;
                mul_b = {16'd0, r_dt};
            end
            S_KM: begin
                mul_a = {1'b0, r_kt};
                mul_b = r_cur;
            end
            S_GEFF: begin
                mul_a = {15'd0, r_eff};
                mul_b = r_ta;
            end
            S_TAU: begin
                mul_a = {1'b0, r_gear};
                mul_b = r_ta;
            end
            default: ;
        endcase
    end

    dcm_mul u_mul (
        .i_clk  (i_clk),
        .i_load (mul_load),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_q    (mul_q)
    );

    // single wide adder for the saturating sums
    always_comb begin
        unique case (r_state)
            S_DIFF:  sum = dcm_pkg::SHIFT_W'(r_drive) - dcm_pkg::SHIFT_W'(r_ta)
                           - dcm_pkg::SHIFT_W'(r_tb);
            S_CUR:   sum = dcm_pkg::SHIFT_W'(r_cur) + dcm_pkg::SHIFT_W'(r_ta);
            S_NET:   sum = dcm_pkg::SHIFT_W'(r_ta) - $signed({17'd0, r_friction});
            default: sum = dcm_pkg::SHIFT_W'(r_ta);
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        if (is_mul) begin
            if (!r_ph) begin
                n_ph = 1'b1;
            end else if (r_state != S_TAU || out_free) begin
                n_ph = 1'b0;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_take && i_opcode == dcm_pkg::OP_DUTY) begin
                    n_state = S_SQRT;
                end else if (in_take && i_opcode == dcm_pkg::OP_TICK) begin
                    n_state = S_KETR;
                end
            end
            S_SQRT:  if (sq_done) n_state = S_VMUL;
            S_VMUL:  if (r_ph) n_state = S_IDLE;
            S_KETR:  if (r_ph) n_state = S_BEMF;
            S_BEMF:  if (r_ph) n_state = S_RDROP;
            S_RDROP: if (r_ph) n_state = S_DIFF;
            S_DIFF:  n_state = S_IDOT;
            S_IDOT:  if (r_ph) n_state = S_DELTA;
            S_DELTA: if (r_ph) n_state = S_CUR;
            S_CUR:   n_state = S_KM;
            S_KM:    if (r_ph) n_state = S_NET;
            S_NET:   n_state = S_GEFF;
            S_GEFF:  if (r_ph) n_state = S_TAU;
            S_TAU:   if (r_ph && out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
        end
    end

    // motor state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= '0;
            r_speed <= '0;
            r_cur   <= '0;
        end else begin
            if (in_take && i_opcode == dcm_pkg::OP_SPEED) begin
                r_speed <= i_value;
            end
            if (r_state == S_VMUL && r_ph) begin
                // magnitude is non-negative, apply the duty sign then clamp
                r_drive <= r_neg ? dcm_pkg::sat32(-mul_q) : dcm_pkg::sat32(mul_q);
            end
            if (r_state == S_CUR) begin
                r_cur <= dcm_pkg::sat32(sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_dt  <= i_step_time;
            r_neg <= i_value[dcm_pkg::Q_W-1];
        end
        if (r_ph && (r_state == S_KETR || r_state == S_BEMF || r_state == S_IDOT
                     || r_state == S_DELTA || r_state == S_KM || r_state == S_GEFF)) begin
            r_ta <= dcm_pkg::sat32(mul_q);
        end
        if (r_ph && r_state == S_RDROP) begin
            r_tb <= dcm_pkg::sat32(mul_q);
        end
        if (r_state == S_DIFF || r_state == S_NET) begin
            r_ta <= dcm_pkg::sat32(sum);
        end
    end

    // output register: a finished torque waits here while the input side idles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_TAU && r_ph && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TAU && r_ph && out_free) begin
            r_torque <= dcm_pkg::sat32(mul_q);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_torque    = r_torque;

    // checks

    // a duty beat always starts the square root sequence
    a_duty_to_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_opcode == dcm_pkg::OP_DUTY) |=> (r_state == S_SQRT))
        else $error("duty beat did not start the square root");

    // the root unit finishes only while the sequencer waits for it
    a_sqrt_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_SQRT))
        else $error("square root finished outside its wait state");

    // a new torque beat comes only from the last multiply of a tick
    a_out_from_tau: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_TAU && $past(r_ph)))
        else $error("torque beat appeared without a finished tick");

    // the second multiply phase exists only in multiply steps
    a_phase_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph |-> is_mul)
        else $error("multiply phase set outside a multiply step");

endmodule
`default_nettype wire

>>> tb/tb.sv
// tb: self-checking testbench for dc_motor_current_torque_step with a built-in q16.16 motor predictor
module tb;

    typedef longint unsigned t_u64;

    // opcode 3 has no meaning in the block, it must be swallowed silently
    localparam logic [dcm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam longint Q_TOP    = 64'sd2147483647;
    localparam longint Q_BOTTOM = -64'sd2147483648;

    // register settings used per phase
    typedef enum int {SET_MOTOR, SET_WIDE, SET_TOP, SET_ZERO} t_setting;
    // receiver behavior between long hold-offs
    typedef enum int {RX_OPEN, RX_CHOPPY, RX_BLOCKED} t_rx_style;

    // every input known from time zero
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    logic [dcm_pkg::OP_W-1:0]       i_opcode    = dcm_pkg::OP_DUTY;
    logic signed [dcm_pkg::Q_W-1:0] i_value     = '0;
    logic [dcm_pkg::DT_W-1:0]       i_step_time = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic signed [dcm_pkg::Q_W-1:0] o_torque;
    logic                           i_cfg_we    = 1'b0;
    logic [dcm_pkg::ADDR_W-1:0]     i_cfg_addr  = dcm_pkg::REG_SUPPLY;
    logic [dcm_pkg::REG_W-1:0]      i_cfg_data  = '0;

    // predictor copy of the registers and the motor state
    logic [dcm_pkg::REG_W-1:0] motor_regs [8];
    logic [dcm_pkg::REG_W-1:0] pending_regs [8];
    dcm_pkg::t_q drive_volts;
    dcm_pkg::t_q shaft_rate;
    dcm_pkg::t_q arm_current;

    // torque beats still owed by the block, oldest first
    dcm_pkg::t_q torque_due [$];
    dcm_pkg::t_q torque_want;

    int fail_count   = 0;
    int gap_max      = 0;
    int burst_left   = 0;
    int hold_request = 0;
    bit offering     = 1'b0;

    dc_motor_current_torque_step i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_step_time (i_step_time),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_torque    (o_torque),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // q16.16 arithmetic of the motor model
    // ------------------------------------------------------------------

    function automatic longint q_clamp(input longint x);
        if (x > Q_TOP) begin
            return Q_TOP;
        end
        if (x < Q_BOTTOM) begin
            return Q_BOTTOM;
        end
        return x;
    endfunction

    // exact product, floor shift by 16, then clamp
    function automatic longint q_mul(input longint a, input longint b);
        return q_clamp((a * b) >>> 16);
    endfunction

    // bitwise integer square root, floor
    function automatic t_u64 root_floor(input t_u64 x);
        t_u64 res;
        t_u64 pos;
        res = 0;
        pos = t_u64'(1) << 62;
        while (pos > x) pos >>= 2;
        while (pos != 0) begin
            if (x >= res + pos) begin
                x   -= res + pos;
                res  = (res >> 1) + pos;
            end else begin
                res >>= 1;
            end
            pos >>= 2;
        end
        return res;
    endfunction

    // updates the motor state for one accepted beat, queues the torque on a tick
    task automatic motor_accept(input logic [dcm_pkg::OP_W-1:0] op, input dcm_pkg::t_q val,
                                input logic [dcm_pkg::DT_W-1:0] dt);
        longint mag;
        longint sv;
        longint bemf;
        longint rdrop;
        longint diff;
        longint idot;
        longint delta;
        longint cur;
        longint km;
        longint net_torque;
        longint geff;
        t_u64   root;
        t_u64   volts;
        case (op)
            dcm_pkg::OP_DUTY: begin
                // sign(duty) * sqrt(|duty|) * supply, no clipping of the duty
                mag   = (val < 0) ? -longint'(val) : longint'(val);
                root  = root_floor(t_u64'(mag) << 16);
                volts = (root * t_u64'(motor_regs[dcm_pkg::REG_SUPPLY])) >> 16;
                if (volts > (t_u64'(1) << 32)) begin
                    volts = t_u64'(1) << 32;
                end
                sv = longint'(volts);
                if (val < 0) begin
                    sv = -sv;
                end
                drive_volts = dcm_pkg::t_q'(q_clamp(sv));
            end
            dcm_pkg::OP_SPEED: begin
                shaft_rate = val;
            end
            dcm_pkg::OP_TICK: begin
                // forward euler step of the armature current
                bemf  = q_mul(q_mul(longint'(motor_regs[dcm_pkg::REG_KE]),
                                    longint'(motor_regs[dcm_pkg::REG_GEAR])),
                              longint'(shaft_rate));
                rdrop = q_mul(longint'(motor_regs[dcm_pkg::REG_RES]), longint'(arm_current));
                diff  = q_clamp(longint'(drive_volts) - bemf - rdrop);
                idot  = q_mul(diff, longint'(motor_regs[dcm_pkg::REG_INV_L]));
                delta = q_mul(idot, longint'(dt));
                cur   = q_clamp(longint'(arm_current) + delta);
                arm_current = dcm_pkg::t_q'(cur);
                // torque through the gearbox
                km         = q_mul(longint'(motor_regs[dcm_pkg::REG_KT]), cur);
                net_torque = q_clamp(km - longint'(motor_regs[dcm_pkg::REG_FRICTION]));
                geff       = q_mul(longint'(motor_regs[dcm_pkg::REG_EFF]), net_torque);
                torque_due.push_back(
                    dcm_pkg::t_q'(q_mul(longint'(motor_regs[dcm_pkg::REG_GEAR]), geff)));
            end
            default: begin
                // unused opcode: no state change, no beat
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // offers one input beat, holds it until taken, then maybe idles
    task automatic send_item(input logic [dcm_pkg::OP_W-1:0] op, input dcm_pkg::t_q val,
                             input logic [dcm_pkg::DT_W-1:0] dt);
        i_in_valid  <= 1'b1;
        offering     = 1'b1;
        i_opcode    <= op;
        i_value     <= val;
        i_step_time <= dt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        motor_accept(op, val, dt);
        // bursts of back-to-back beats separated by random gaps
        if (gap_max != 0) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                i_in_valid <= 1'b0;
                offering    = 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    // lets every owed torque beat arrive, then covers a duty still in the square root
    task automatic drain_block();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering    = 1'b0;
        end
        while (torque_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // writes all eight registers on consecutive edges, block idle
    task automatic apply_regs();
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 8; k++) begin
            i_cfg_addr <= dcm_pkg::ADDR_W'(k);
            i_cfg_data <= pending_regs[k];
            @(posedge i_clk);
            // efficiency keeps only its own 17 bits
            if (dcm_pkg::ADDR_W'(k) == dcm_pkg::REG_EFF) begin
                motor_regs[k] = dcm_pkg::REG_W'(pending_regs[k][dcm_pkg::EFF_W-1:0]);
            end else begin
                motor_regs[k] = pending_regs[k];
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic choose_settings(input t_setting kind);
        case (kind)
            SET_MOTOR: begin
                // plausible small motor, gearbox and supply
                pending_regs[dcm_pkg::REG_SUPPLY]   =
                    dcm_pkg::REG_W'($urandom_range(0, 48 * 65536));
                pending_regs[dcm_pkg::REG_KE]       = dcm_pkg::REG_W'($urandom_range(0, 65536));
                pending_regs[dcm_pkg::REG_GEAR]     =
                    dcm_pkg::REG_W'($urandom_range(16384, 20 * 65536));
                pending_regs[dcm_pkg::REG_RES]      =
                    dcm_pkg::REG_W'($urandom_range(6554, 5 * 65536));
                pending_regs[dcm_pkg::REG_INV_L]    =
                    dcm_pkg::REG_W'($urandom_range(65536, 200 * 65536));
                pending_regs[dcm_pkg::REG_KT]       = dcm_pkg::REG_W'($urandom_range(0, 65536));
                pending_regs[dcm_pkg::REG_EFF]      = dcm_pkg::REG_W'($urandom_range(0, 65536));
                pending_regs[dcm_pkg::REG_FRICTION] = dcm_pkg::REG_W'($urandom_range(0, 16384));
            end
            SET_WIDE: begin
                foreach (pending_regs[k]) pending_regs[k] = dcm_pkg::REG_W'($urandom);
            end
            SET_TOP: begin
                // all ones, efficiency ends up above one
                foreach (pending_regs[k]) pending_regs[k] = '1;
            end
            default: begin
                foreach (pending_regs[k]) pending_regs[k] = '0;
            end
        endcase
    endtask

    // mostly realistic motor commands, some full-range words and unused opcodes
    task automatic send_random_item(inout int counted);
        int                          pick;
        bit                          wild;
        logic [dcm_pkg::OP_W-1:0]    op;
        dcm_pkg::t_q                 val;
        logic [dcm_pkg::DT_W-1:0]    dt;
        pick = $urandom_range(0, 99);
        wild = ($urandom_range(0, 3) == 0);
        val  = $urandom;
        dt   = dcm_pkg::DT_W'($urandom);
        if (pick < 8) begin
            op = OP_UNUSED;
        end else if (pick < 33) begin
            op = dcm_pkg::OP_DUTY;
            if (!wild) begin
                val = $urandom_range(0, 131072) - 65536;
            end
        end else if (pick < 53) begin
            op = dcm_pkg::OP_SPEED;
            if (!wild) begin
                val = $urandom_range(0, 400 * 65536) - 200 * 65536;
            end
        end else begin
            op = dcm_pkg::OP_TICK;
            if (!wild) begin
                dt = dcm_pkg::DT_W'($urandom_range(0, 3000));
            end
        end
        send_item(op, val, dt);
        if (op != OP_UNUSED) begin
            counted++;
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: own stall pattern plus long hold-offs on request
    // ------------------------------------------------------------------

    initial begin : rx_pacing
        int        n;
        int        stall_left;
        t_rx_style stall_style;
        stall_left  = 0;
        stall_style = RX_OPEN;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                // long hold-off, counted here so the sender keeps pushing meanwhile
                n            = hold_request;
                hold_request = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
                stall_style  = RX_OPEN;
                stall_left   = $urandom_range(20, 80);
            end else begin
                if (stall_left == 0) begin
                    case ($urandom_range(0, 3)) inside
                        0, 1: begin
                            stall_style = RX_OPEN;
                            stall_left  = $urandom_range(10, 200);
                        end
                        2: begin
                            stall_style = RX_CHOPPY;
                            stall_left  = $urandom_range(10, 60);
                        end
                        default: begin
                            stall_style = RX_BLOCKED;
                            stall_left  = $urandom_range(1, 25);
                        end
                    endcase
                end
                stall_left--;
                case (stall_style)
                    RX_OPEN:    i_out_stall <= 1'b0;
                    RX_CHOPPY:  i_out_stall <= 1'($urandom_range(0, 1));
                    default:    i_out_stall <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // checking: every taken torque beat against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (torque_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("torque beat %0d with nothing expected", o_torque);
                end
            end else begin
                torque_want = torque_due.pop_front();
                if (o_torque !== torque_want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("torque mismatch: expected %0d, got %0d",
                                 torque_want, o_torque);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values of the registers, field extremes and the odd cases
    task automatic test_reset_defaults();
        gap_max    = 6;
        burst_left = 0;
        send_item(dcm_pkg::OP_TICK, 0, 16'd0);                       // zero-length tick
        send_item(dcm_pkg::OP_TICK, 0, 16'hFFFF);
        send_item(dcm_pkg::OP_DUTY, 32'sd65536, 16'd0);              // full duty, 12 v
        send_item(dcm_pkg::OP_TICK, 0, 16'd1);
        send_item(dcm_pkg::OP_TICK, 0, 16'hFFFF);
        send_item(dcm_pkg::OP_SPEED, 32'sh7FFF_FFFF, 16'd0);         // back-emf saturates
        send_item(dcm_pkg::OP_TICK, 0, 16'hFFFF);
        send_item(dcm_pkg::OP_SPEED, 32'sh8000_0000, 16'd0);
        send_item(dcm_pkg::OP_TICK, 0, 16'hFFFF);
        send_item(dcm_pkg::OP_DUTY, -32'sd65536, 16'hFFFF);
        send_item(dcm_pkg::OP_DUTY, 32'sh7FFF_FFFF, 16'hFFFF);       // duty far beyond one
        send_item(dcm_pkg::OP_TICK, 32'sh7FFF_FFFF, 16'hFFFF);
        send_item(dcm_pkg::OP_DUTY, 32'sh8000_0000, 16'd0);          // most negative duty
        send_item(dcm_pkg::OP_TICK, 32'sh8000_0000, 16'hFFFF);
        send_item(dcm_pkg::OP_DUTY, 32'sd1, 16'd0);
        send_item(dcm_pkg::OP_DUTY, -32'sd1, 16'd0);
        send_item(dcm_pkg::OP_TICK, 0, 16'h8000);
        send_item(dcm_pkg::OP_DUTY, 32'sd0, 16'd0);                  // zero duty, zero volts
        send_item(OP_UNUSED, 32'sh7FFF_FFFF, 16'hFFFF);              // must change nothing
        send_item(OP_UNUSED, 32'sh8000_0000, 16'd0);
        send_item(dcm_pkg::OP_SPEED, 32'sd0, 16'd0);
        send_item(dcm_pkg::OP_TICK, 0, 16'h8000);
    endtask

    // all registers at their top, efficiency above one, then all at zero
    task automatic test_register_extremes();
        drain_block();
        choose_settings(SET_TOP);
        apply_regs();
        send_item(dcm_pkg::OP_DUTY, 32'sh8000_0000, 16'd0);
        send_item(dcm_pkg::OP_TICK, 0, 16'hFFFF);
        send_item(dcm_pkg::OP_SPEED, 32'sh7FFF_FFFF, 16'd0);
        send_item(dcm_pkg::OP_TICK, 0, 16'd1);
        drain_block();
        choose_settings(SET_ZERO);
        apply_regs();
        send_item(dcm_pkg::OP_DUTY, 32'sh7FFF_FFFF, 16'd0);
        send_item(dcm_pkg::OP_TICK, 0, 16'hFFFF);
        send_item(dcm_pkg::OP_TICK, 0, 16'd0);
    endtask

    // several register settings, each with its own idling style
    task automatic test_random_settings();
        int       counted;
        t_setting plan [8];
        int       gaps [8];
        plan = '{SET_MOTOR, SET_WIDE, SET_MOTOR, SET_MOTOR,
                 SET_WIDE, SET_MOTOR, SET_TOP, SET_MOTOR};
        gaps = '{0, 8, 45, 20, 3, 45, 12, 30};
        foreach (plan[p]) begin
            drain_block();
            choose_settings(plan[p]);
            apply_regs();
            gap_max    = gaps[p];
            burst_left = 0;
            counted    = 0;
            while (counted < 195) send_random_item(counted);
        end
    endtask

    // receiver holds off for a long stretch while beats keep coming
    task automatic test_output_hold();
        int counted;
        drain_block();
        choose_settings(SET_MOTOR);
        apply_regs();
        gap_max      = 0;
        counted      = 0;
        hold_request = 400;
        while (counted < 120) send_random_item(counted);
    endtask

    initial begin
        // predictor registers at their reset values
        motor_regs[dcm_pkg::REG_SUPPLY]   = 31'd786432;
        motor_regs[dcm_pkg::REG_KE]       = 31'd65536;
        motor_regs[dcm_pkg::REG_GEAR]     = 31'd65536;
        motor_regs[dcm_pkg::REG_RES]      = 31'd65536;
        motor_regs[dcm_pkg::REG_INV_L]    = 31'd65536;
        motor_regs[dcm_pkg::REG_KT]       = 31'd65536;
        motor_regs[dcm_pkg::REG_EFF]      = 31'd65536;
        motor_regs[dcm_pkg::REG_FRICTION] = 31'd0;
        drive_volts = '0;
        shaft_rate  = '0;
        arm_current = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_settings();
        test_output_hold();

        drain_block();
        if (torque_due.size() != 0) begin
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("dc_motor_current_torque_step verification clean");
        end else begin
            $display("dc_motor_current_torque_step verification failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("dc_motor_current_torque_step verification failed");
        $finish;
    end

endmodule
